>>> rtl/core/bfs_am_pkg.sv
// types and constants shared by the breadth-first search engine
package bfs_am_pkg;

  localparam int ROW_W  = 32;
  localparam int NODE_W = 5;
  localparam int VCNT_W = 6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 6'd32;

  // one input request
  typedef struct packed {
    logic              operation;
    logic [NODE_W-1:0] row_index;
    logic [ROW_W-1:0]  row_bits;
    logic [NODE_W-1:0] start_node;
  } in_item_t;

  // one result
  typedef struct packed {
    logic [NODE_W-1:0] visited_node;
    logic              last_of_walk;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic wr_row;
    logic seed;
    logic fetch;
    logic rd_row;
    logic push;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_ok;
    logic pend_empty;
    logic fifo_empty;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/bfs_adjacency_matrix.sv
// breadth-first search engine over a stored adjacency matrix
// load request: accepted while idle, no result
// start request: each visited vertex takes a queue read, a row store read, one enqueue
//   per cycle for each new neighbour and then its result; a stalled result holds the
//   engine; a start with an out-of-range vertex is dropped with no result; the next
//   start is taken after the last result
// reset: control cleared, vertex count 32, adjacency rows undefined until loaded
module bfs_adjacency_matrix #(
  parameter int VERTEX_LIMIT = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bfs_am_pkg::in_item_t           in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bfs_am_pkg::out_item_t          out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfs_am_pkg::VCNT_W-1:0]  cfg_data
);

  bfs_am_pkg::cmd_t    cmd;
  bfs_am_pkg::status_t sts;
  logic                cfg_we;

  // configuration write port
  bfs_am_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_we    (cfg_we)
  );

  // sequencer
  bfs_am_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.operation),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and result path
  bfs_am_dpath #(
    .VERTEX_LIMIT (VERTEX_LIMIT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/bfs_am_ctrl.sv
// sequencing state machine for the breadth-first search engine
module bfs_am_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_stall,
  input  bfs_am_pkg::status_t sts,
  output bfs_am_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ROW,
    ST_SCAN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == bfs_am_pkg::OP_LOAD) begin
            cmd.wr_row = 1'b1;
          end else if (sts.start_ok) begin
            cmd.seed  = 1'b1;
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_ROW;
      end
      ST_ROW: begin
        cmd.rd_row = 1'b1;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts.pend_empty) begin
          cmd.push = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.fifo_empty ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/bfs_am_dpath.sv
// adjacency store, queue, visited mask and result register
module bfs_am_dpath #(
  parameter int VERTEX_LIMIT = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bfs_am_pkg::in_item_t                 in_data,
  input  logic                                 cfg_we,
  input  logic [bfs_am_pkg::VCNT_W-1:0]        cfg_data,
  input  bfs_am_pkg::cmd_t                     cmd,
  output bfs_am_pkg::status_t                  sts,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output bfs_am_pkg::out_item_t                out_data
);

  localparam int ADDR_W = (VERTEX_LIMIT > 1) ? $clog2(VERTEX_LIMIT) : 1;
  localparam int PTR_W  = $clog2(VERTEX_LIMIT + 1);
  localparam int ROW_W  = bfs_am_pkg::ROW_W;
  localparam int NODE_W = bfs_am_pkg::NODE_W;

  logic [ROW_W-1:0]  adj_mem [VERTEX_LIMIT];
  logic [NODE_W-1:0] fifo_mem [VERTEX_LIMIT];

  logic [bfs_am_pkg::VCNT_W-1:0] vcnt_r;
  logic [ROW_W-1:0]  visited_r;
  logic [ROW_W-1:0]  pend_r;
  logic              ld_pend_r;
  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  tail_r;
  logic [NODE_W-1:0] cur_r;
  logic [ROW_W-1:0]  row_r;
  logic              out_valid_r;
  bfs_am_pkg::out_item_t out_r;

  logic [ROW_W-1:0]  lim_mask;
  logic [ROW_W-1:0]  pend_cur;
  logic [ROW_W-1:0]  pend_oh;
  logic [NODE_W-1:0] pend_idx;
  logic              row_ok;
  logic              fifo_we;
  logic [ADDR_W-1:0] fifo_waddr;
  logic [NODE_W-1:0] fifo_wdata;

  // neighbour scan limit as a bit mask
  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      lim_mask[j] = (bfs_am_pkg::VCNT_W'(j) < vcnt_r) && (j < VERTEX_LIMIT);
    end
  end

  // pending neighbours: fresh from the row on the first scan cycle
  assign pend_cur = ld_pend_r ? (row_r & lim_mask & ~visited_r) : pend_r;
  assign pend_oh  = pend_cur & (~pend_cur + ROW_W'(1));

  always_comb begin
    pend_idx = '0;
    for (int j = 0; j < ROW_W; j++) begin
      pend_idx = pend_idx | (pend_oh[j] ? NODE_W'(j) : '0);
    end
  end

  // index bounds against the store depth
  assign row_ok       = int'(in_data.row_index) < VERTEX_LIMIT;
  assign sts.start_ok = int'(in_data.start_node) < VERTEX_LIMIT;
  assign sts.pend_empty = (pend_cur == '0);
  assign sts.fifo_empty = (head_r == tail_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  // vertex count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= bfs_am_pkg::VCNT_RESET;
    end else if (cfg_we) begin
      vcnt_r <= cfg_data;
    end
  end

  // adjacency store
  always_ff @(posedge clk) begin
    if (cmd.wr_row && row_ok) begin
      adj_mem[ADDR_W'(in_data.row_index)] <= in_data.row_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_row) begin
      row_r <= adj_mem[ADDR_W'(cur_r)];
    end
  end

  // queue storage
  assign fifo_we    = cmd.seed || cmd.push;
  assign fifo_waddr = cmd.seed ? '0 : tail_r[ADDR_W-1:0];
  assign fifo_wdata = cmd.seed ? in_data.start_node : pend_idx;

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= fifo_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      cur_r <= fifo_mem[head_r[ADDR_W-1:0]];
    end
  end

  // queue pointers, visited mask and pending set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      visited_r <= '0;
      pend_r    <= '0;
      ld_pend_r <= 1'b0;
    end else begin
      ld_pend_r <= cmd.rd_row;
      if (cmd.seed) begin
        head_r    <= '0;
        tail_r    <= PTR_W'(1);
        visited_r <= ROW_W'(1) << in_data.start_node;
        pend_r    <= '0;
      end else begin
        if (cmd.fetch) begin
          head_r <= head_r + PTR_W'(1);
        end
        if (cmd.push) begin
          tail_r    <= tail_r + PTR_W'(1);
          visited_r <= visited_r | pend_oh;
          pend_r    <= pend_cur & ~pend_oh;
        end else if (ld_pend_r) begin
          pend_r <= pend_cur;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.visited_node <= cur_r;
      out_r.last_of_walk <= (head_r == tail_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/bfs_am_top_unused_guard.sv
// vertex count write port: accepts one register write per cycle
module bfs_am_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  output logic                          cfg_we
);

  logic ready_r;

  // ready is registered: the port opens after reset is released and stays open
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= 1'b1;
    end
  end

  assign cfg_ready = ready_r;
  assign cfg_we    = cfg_valid && ready_r;

endmodule
